FILE: src/salc_pkg.sv
// ----------------------------------------------------------------------------
// salc_pkg: shared types and codes of the LRU cache tag controller
// Opcodes, fill kinds, stream widths and the lookup result record.
// ----------------------------------------------------------------------------
package salc_pkg;

   // request field widths (fixed by the stream format)
   localparam int OP_W   = 3;
   localparam int ADDR_W = 32;
   localparam int WAY_OW = 3;
   localparam int FILL_W = 2;
   localparam int REQ_W  = 40;   // 37 payload bits padded to whole bytes
   localparam int RSP_W  = 40;   // 39 payload bits padded to whole bytes

   typedef enum logic [OP_W-1:0] {
      OP_READ  = 3'd0,
      OP_WRITE = 3'd1,
      OP_ALLOC = 3'd2,
      OP_TOUCH = 3'd3,
      OP_COPY  = 3'd4
   } op_type;

   typedef enum logic [FILL_W-1:0] {
      FILL_NONE   = 2'd0,
      FILL_REFILL = 2'd1,
      FILL_ZERO   = 2'd2,
      FILL_LINE   = 2'd3
   } fill_type;

   typedef struct packed {
      logic [FILL_W-1:0] fill_kind;
      logic [ADDR_W-1:0] writeback_addr;
      logic              writeback;
      logic [WAY_OW-1:0] way;
      logic              hit;
   } result_type;

endpackage

FILE: src/salc_ram.sv
// ----------------------------------------------------------------------------
// salc_ram: generic simple dual-port RAM
// One write port, one read port with registered read data (old data on
// a same-address write).
// ----------------------------------------------------------------------------
module salc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [AW-1:0]        rd_addr,
   output logic [WIDTH-1:0]     rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/salc_lookup.sv
// ----------------------------------------------------------------------------
// salc_lookup: tag compare, victim choice and set update
// Works on one set row: finds the hit way, picks the LRU victim, builds the
// new tag/valid/dirty entries and the new LRU order, and forms the response.
// ----------------------------------------------------------------------------
module salc_lookup
   import salc_pkg::*;
#(
   parameter int SETS             = 256,
   parameter int WAYS             = 8,
   parameter int LINE_OFFSET_BITS = 6,
   parameter int ADDR_BITS        = 32,
   localparam int IB       = $clog2(SETS + 1) - 1,
   localparam int SHIFT    = LINE_OFFSET_BITS + IB,
   localparam int TAG_W    = (ADDR_BITS - SHIFT > 0) ? ADDR_BITS - SHIFT : 1,
   localparam int ENT_W    = TAG_W + 2,
   localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1,
   localparam int SET_W    = (SETS > 1) ? $clog2(SETS) : 1
) (
   input  logic [OP_W-1:0]          op,
   input  logic [ADDR_W-1:0]        addr,
   input  logic                     line_valid,
   input  logic                     line_dirty,
   input  logic [SET_W-1:0]         set_idx,
   input  logic [WAYS*ENT_W-1:0]    ent_row,
   input  logic [WAYS*WAY_W-1:0]    lru_row,
   output logic [WAYS*ENT_W-1:0]    ent_new,
   output logic [WAYS*WAY_W-1:0]    lru_new,
   output logic                     upd,
   output result_type               res
);
   localparam logic [ADDR_W-1:0] ADDR_MASK = ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

   logic [ADDR_W-1:0] addr_m;
   logic [ADDR_W-1:0] tag_full;
   logic [TAG_W-1:0]  tag;

   logic [TAG_W-1:0]  tag_a [WAYS];
   logic              val_a [WAYS];
   logic              dir_a [WAYS];
   logic [WAY_W-1:0]  lru_a [WAYS];
   logic [WAY_W-1:0]  lru_n [WAYS];

   logic              hit;
   logic [WAY_W-1:0]  way;
   logic [WAY_W-1:0]  pos;
   logic [TAG_W-1:0]  t_e, nt;
   logic              v_e, d_e, nv, nd;
   logic              wb, use_lru;
   logic [ADDR_W-1:0] wb_addr;
   fill_type          fill;

   assign addr_m   = addr & ADDR_MASK;
   assign tag_full = addr_m >> SHIFT;
   assign tag      = tag_full[TAG_W-1:0];

   always_comb begin
      for (int i = 0; i < WAYS; i++) begin
         tag_a[i] = ent_row[i*ENT_W +: TAG_W];
         val_a[i] = ent_row[i*ENT_W + TAG_W];
         dir_a[i] = ent_row[i*ENT_W + TAG_W + 1];
         lru_a[i] = lru_row[i*WAY_W +: WAY_W];
      end
   end

   // first valid matching way wins; miss falls back to least recent
   always_comb begin
      hit = 1'b0;
      way = lru_a[0];
      for (int i = 0; i < WAYS; i++) begin
         if (!hit && val_a[i] && (tag_a[i] == tag)) begin
            hit = 1'b1;
            way = WAY_W'(i);
         end
      end
   end

   // move used way to most recent end
   always_comb begin
      pos = '0;
      for (int i = 0; i < WAYS; i++) begin
         if (lru_a[i] == way) begin
            pos = WAY_W'(i);
         end
      end
      for (int i = 0; i < WAYS; i++) begin
         lru_n[i] = lru_a[i];
      end
      for (int i = 0; i < WAYS - 1; i++) begin
         if (WAY_W'(i) >= pos) begin
            lru_n[i] = lru_a[i+1];
         end
      end
      lru_n[WAYS-1] = way;
   end

   assign t_e = tag_a[way];
   assign v_e = val_a[way];
   assign d_e = dir_a[way];
   assign wb_addr = ((ADDR_W'(t_e) << SHIFT) + (ADDR_W'(set_idx) << LINE_OFFSET_BITS))
                    & ADDR_MASK;

   always_comb begin
      nt      = t_e;
      nv      = v_e;
      nd      = d_e;
      wb      = 1'b0;
      use_lru = 1'b0;
      upd     = 1'b0;
      fill    = FILL_NONE;
      res     = '0;
      case (op)
         OP_TOUCH: begin
            use_lru  = hit;
            upd      = 1'b1;
            res.hit  = hit;
            res.way  = WAY_OW'(way);
         end
         OP_READ, OP_WRITE, OP_ALLOC, OP_COPY: begin
            wb = !hit && v_e && d_e;
            if (wb) begin
               nd = 1'b0;
            end
            if (op == OP_COPY) begin
               nt   = tag;
               nv   = line_valid;
               nd   = line_dirty;
               fill = FILL_LINE;
            end else if (!hit) begin
               nt   = tag;
               nv   = 1'b1;
               nd   = 1'b0;
               fill = (op == OP_ALLOC) ? FILL_ZERO : FILL_REFILL;
            end
            if (op == OP_WRITE) begin
               nd = 1'b1;
            end
            use_lru            = 1'b1;
            upd                = 1'b1;
            res.hit            = hit;
            res.way            = WAY_OW'(way);
            res.writeback      = wb;
            res.writeback_addr = wb ? wb_addr : '0;
            res.fill_kind      = fill;
         end
         default: begin
            // unknown op: no update, all-zero response
            upd = 1'b0;
         end
      endcase
   end

   always_comb begin
      ent_new = ent_row;
      ent_new[way*ENT_W +: ENT_W] = {nd, nv, nt};
      lru_new = lru_row;
      if (use_lru) begin
         for (int i = 0; i < WAYS; i++) begin
            lru_new[i*WAY_W +: WAY_W] = lru_n[i];
         end
      end
   end

endmodule

FILE: src/set_assoc_lru_cache_tags.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tags: tag, valid, dirty and true-LRU controller
// Set-associative write-back cache tags with per-set LRU order.
// ----------------------------------------------------------------------------
// Pipeline: an accepted request has its set RAM row read into stage 1, then
//   compare/update loads the result register, which holds the response until
//   it is taken.
// Throughput: one request per cycle while the response output is not held by
//   rsp_tready; the set RAM has one read and one write port, a same-set
//   request right behind another takes the written row from a bypass register.
// Reset: control is cleared and every per-set row flag drops, so each set
//   reads as empty with LRU order way 0..WAYS-1. No clearing pass is needed.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_tags
   import salc_pkg::*;
#(
   parameter int SETS             = 256,
   parameter int WAYS             = 8,
   parameter int LINE_OFFSET_BITS = 6,
   parameter int ADDR_BITS        = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // [2:0] op, [34:3] addr, [35] line_valid, [36] line_dirty, [39:37] zero
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // [0] hit, [3:1] way, [4] writeback, [36:5] writeback_addr,
   // [38:37] fill_kind, [39] zero
   output logic [RSP_W-1:0] rsp_tdata
);
   localparam int IB     = $clog2(SETS + 1) - 1;
   localparam int SHIFT  = LINE_OFFSET_BITS + IB;
   localparam int TAG_W  = (ADDR_BITS - SHIFT > 0) ? ADDR_BITS - SHIFT : 1;
   localparam int ENT_W  = TAG_W + 2;
   localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int ENTS_W = WAYS * ENT_W;
   localparam int LRU_W  = WAYS * WAY_W;
   localparam int ROW_W  = ENTS_W + LRU_W;
   localparam logic [ADDR_W-1:0] ADDR_MASK = ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);
   localparam logic [ADDR_W-1:0] SET_MASK  = ADDR_W'(SETS - 1);

   function automatic logic [LRU_W-1:0] lru_init();
      logic [LRU_W-1:0] r;
      r = '0;
      for (int w = 0; w < WAYS; w++) begin
         r[w*WAY_W +: WAY_W] = WAY_W'(w);
      end
      return r;
   endfunction

   localparam logic [ROW_W-1:0] ROW_RESET = {lru_init(), {ENTS_W{1'b0}}};

   // request fields
   logic [OP_W-1:0]   req_op;
   logic [ADDR_W-1:0] req_addr;
   logic              req_lv, req_ld;
   logic [ADDR_W-1:0] req_set_full;
   logic [SET_W-1:0]  req_set;
   logic              accept;

   // stage 1: request waiting on its set row
   logic              s1_valid_ff, s1_valid_in;
   logic [OP_W-1:0]   s1_op_ff, s1_op_in;
   logic [ADDR_W-1:0] s1_addr_ff, s1_addr_in;
   logic              s1_lv_ff, s1_lv_in;
   logic              s1_ld_ff, s1_ld_in;
   logic [SET_W-1:0]  s1_set_ff, s1_set_in;
   logic              s1_rowok_ff, s1_rowok_in;
   logic              byp_vld_ff, byp_vld_in;
   logic [ROW_W-1:0]  byp_row_ff, byp_row_in;

   // per-set "row written since reset" flags
   logic [SETS-1:0]   row_ok_ff, row_ok_in;

   // output register
   logic              out_valid_ff, out_valid_in;
   result_type        out_res_ff, out_res_in;

   logic              advance;
   logic              we;
   logic [ROW_W-1:0]  ram_rd;
   logic [ROW_W-1:0]  row_cur;
   logic [ENTS_W-1:0] ent_new;
   logic [LRU_W-1:0]  lru_new;
   logic              upd;
   result_type        res;

   assign req_op       = req_tdata[2:0];
   assign req_addr     = req_tdata[34:3];
   assign req_lv       = req_tdata[35];
   assign req_ld       = req_tdata[36];
   assign req_set_full = ((req_addr & ADDR_MASK) >> LINE_OFFSET_BITS) & SET_MASK;
   assign req_set      = req_set_full[SET_W-1:0];

   // stage 1 moves on when the output register is free or being drained
   assign advance    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;
   assign we         = advance && upd;

   // row seen by the lookup: bypass beats RAM, untouched rows read as reset
   always_comb begin
      if (byp_vld_ff) begin
         row_cur = byp_row_ff;
      end else if (s1_rowok_ff) begin
         row_cur = ram_rd;
      end else begin
         row_cur = ROW_RESET;
      end
   end

   salc_ram #(
      .WIDTH (ROW_W),
      .DEPTH (SETS)
   ) u_set_ram (
      .clock   (clock),
      .wr_en   (we),
      .wr_addr (s1_set_ff),
      .wr_data ({lru_new, ent_new}),
      .rd_en   (accept),
      .rd_addr (req_set),
      .rd_data (ram_rd)
   );

   salc_lookup #(
      .SETS             (SETS),
      .WAYS             (WAYS),
      .LINE_OFFSET_BITS (LINE_OFFSET_BITS),
      .ADDR_BITS        (ADDR_BITS)
   ) u_lookup (
      .op         (s1_op_ff),
      .addr       (s1_addr_ff),
      .line_valid (s1_lv_ff),
      .line_dirty (s1_ld_ff),
      .set_idx    (s1_set_ff),
      .ent_row    (row_cur[ENTS_W-1:0]),
      .lru_row    (row_cur[ROW_W-1:ENTS_W]),
      .ent_new    (ent_new),
      .lru_new    (lru_new),
      .upd        (upd),
      .res        (res)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_op_in    = s1_op_ff;
      s1_addr_in  = s1_addr_ff;
      s1_lv_in    = s1_lv_ff;
      s1_ld_in    = s1_ld_ff;
      s1_set_in   = s1_set_ff;
      s1_rowok_in = s1_rowok_ff;
      byp_vld_in  = byp_vld_ff;
      byp_row_in  = byp_row_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_op_in    = req_op;
         s1_addr_in  = req_addr;
         s1_lv_in    = req_lv;
         s1_ld_in    = req_ld;
         s1_set_in   = req_set;
         s1_rowok_in = row_ok_ff[req_set];
         // same set written this edge: RAM returns the old row, keep the new one
         byp_vld_in  = we && (s1_set_ff == req_set);
         byp_row_in  = {lru_new, ent_new};
      end else if (advance) begin
         s1_valid_in = 1'b0;
         byp_vld_in  = 1'b0;
      end
   end

   always_comb begin
      row_ok_in = row_ok_ff;
      if (we) begin
         row_ok_in[s1_set_ff] = 1'b1;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_res_in   = out_res_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_res_in   = res;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         byp_vld_ff   <= 1'b0;
         row_ok_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         byp_vld_ff   <= byp_vld_in;
         row_ok_ff    <= row_ok_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff    <= s1_op_in;
      s1_addr_ff  <= s1_addr_in;
      s1_lv_ff    <= s1_lv_in;
      s1_ld_ff    <= s1_ld_in;
      s1_set_ff   <= s1_set_in;
      s1_rowok_ff <= s1_rowok_in;
      byp_row_ff  <= byp_row_in;
      out_res_ff  <= out_res_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_W - $bits(result_type)){1'b0}}, out_res_ff};

   // ---------------------------------------------------------------- checks
   // a bypassed row only exists for a request sitting in stage 1
   a_byp_has_req: assert property (@(posedge clock) disable iff (reset)
      byp_vld_ff |-> s1_valid_ff)
      else $error("bypass row without a stage 1 request");

   // a victim writeback only ever comes from a miss
   a_wb_on_miss: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_res_ff.writeback |-> !out_res_ff.hit)
      else $error("writeback reported on a hit");

   // writeback address is zero unless a writeback is reported
   a_wb_addr_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_res_ff.writeback |-> out_res_ff.writeback_addr == '0)
      else $error("writeback address without writeback");

   // a written set is flagged as holding real data from then on
   a_row_flag: assert property (@(posedge clock) disable iff (reset)
      we |=> row_ok_ff[$past(s1_set_ff)])
      else $error("set row flag not raised after write");

endmodule

FILE: dv/tb_set_assoc_lru_cache_tags.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_set_assoc_lru_cache_tags: stream-level check of the LRU cache tag block
// Drives read, write, allocate, touch, copy and illegal-op requests, predicts
// hit, way, writeback and fill kind per request from a shadow copy of tags,
// valid, dirty and LRU order, and compares every response in order.
// ----------------------------------------------------------------------------
module tb_set_assoc_lru_cache_tags
   import salc_pkg::*;
();

   // geometry of the block as instantiated (default parameters)
   localparam int N_SETS = 256;
   localparam int N_WAYS = 8;
   localparam int OFF_W  = 6;
   localparam int IDX_W  = 8;
   localparam int TAG_W  = ADDR_W - OFF_W - IDX_W;

   // ops above OP_COPY are illegal and must give an all-zero response
   localparam logic [OP_W-1:0] OP_UNKNOWN_FIRST = 3'd5;
   localparam logic [OP_W-1:0] OP_UNKNOWN_MID   = 3'd6;
   localparam logic [OP_W-1:0] OP_UNKNOWN_LAST  = 3'd7;

   // random addresses mostly come from small pools so sets fill and evict
   localparam int TAG_POOL = 12;
   localparam int SET_POOL = 4;
   localparam int PHASE_ITEMS = 300;
   localparam int DIRECTED_SET = 5;

   // receiver back-pressure: long hold after this many responses
   localparam int HOLD_AT     = 700;
   localparam int HOLD_CYCLES = 80;

   // request fields, highest bits first, matching the req_tdata layout
   typedef struct packed {
      logic              line_dirty;
      logic              line_valid;
      logic [ADDR_W-1:0] addr;
      logic [OP_W-1:0]   op;
   } request_type;

   // ------------------------------------------------------------------------
   // Scoreboard: shadow tag state plus the queue of predicted responses
   // ------------------------------------------------------------------------
   class tag_scoreboard;
      logic [TAG_W-1:0] tag_q   [N_SETS][N_WAYS];
      bit               valid_q [N_SETS][N_WAYS];
      bit               dirty_q [N_SETS][N_WAYS];
      int unsigned      lru_q   [N_SETS][N_WAYS];   // least recent first
      result_type       expected_q [$];
      int               errors;

      function new();
         errors = 0;
         for (int s = 0; s < N_SETS; s++) begin
            for (int w = 0; w < N_WAYS; w++) begin
               tag_q[s][w]   = '0;
               valid_q[s][w] = 1'b0;
               dirty_q[s][w] = 1'b0;
               lru_q[s][w]   = w;
            end
         end
      endfunction

      // move a way to the most-recent end of its set's order
      function void promote_way(logic [IDX_W-1:0] set, int unsigned w);
         int unsigned pos;
         pos = 0;
         for (int i = 0; i < N_WAYS; i++)
            if (lru_q[set][i] == w) pos = i;
         for (int i = pos; i + 1 < N_WAYS; i++)
            lru_q[set][i] = lru_q[set][i + 1];
         lru_q[set][N_WAYS-1] = w;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // predict the response of an accepted request and update shadow state
      function void note_request(request_type r);
         logic [IDX_W-1:0] set;
         logic [TAG_W-1:0] tag;
         int unsigned      way;
         result_type       res;
         set = r.addr[OFF_W +: IDX_W];
         tag = r.addr[ADDR_W-1 -: TAG_W];
         res = '0;
         way = 0;
         if (r.op > OP_COPY) begin
            expected_q.push_back(res);
            return;
         end
         for (int w = 0; w < N_WAYS; w++) begin
            if (!res.hit && valid_q[set][w] && tag_q[set][w] == tag) begin
               res.hit = 1'b1;
               way = w;
            end
         end
         if (!res.hit) way = lru_q[set][0];
         res.way = way[WAY_OW-1:0];

         if (r.op == OP_TOUCH) begin
            // touch: LRU refresh on hit only, miss leaves everything alone
            if (res.hit) promote_way(set, way);
         end else begin
            if (!res.hit && valid_q[set][way] && dirty_q[set][way]) begin
               res.writeback      = 1'b1;
               res.writeback_addr = {tag_q[set][way], set, {OFF_W{1'b0}}};
               dirty_q[set][way]  = 1'b0;
            end
            if (r.op == OP_COPY) begin
               tag_q[set][way]   = tag;
               valid_q[set][way] = r.line_valid;
               dirty_q[set][way] = r.line_dirty;
               res.fill_kind     = FILL_LINE;
            end else if (!res.hit) begin
               tag_q[set][way]   = tag;
               valid_q[set][way] = 1'b1;
               dirty_q[set][way] = 1'b0;
               res.fill_kind     = (r.op == OP_ALLOC) ? FILL_ZERO : FILL_REFILL;
            end
            if (r.op == OP_WRITE) dirty_q[set][way] = 1'b1;
            promote_way(set, way);
         end
         expected_q.push_back(res);
      endfunction

      function void compare_field(string name, logic [ADDR_W-1:0] exp_v,
                                  logic [ADDR_W-1:0] act_v);
         if (exp_v !== act_v) begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            errors++;
         end
      endfunction

      // compare one accepted response with the oldest prediction
      function void check_response(logic [RSP_W-1:0] d);
         result_type act, exp_r;
         act = d[$bits(result_type)-1:0];
         if (expected_q.size() == 0) begin
            $error("response %h with no request outstanding", d);
            errors++;
            return;
         end
         exp_r = expected_q.pop_front();
         compare_field("hit", exp_r.hit, act.hit);
         compare_field("way", exp_r.way, act.way);
         compare_field("writeback", exp_r.writeback, act.writeback);
         compare_field("writeback_addr", exp_r.writeback_addr, act.writeback_addr);
         compare_field("fill_kind", exp_r.fill_kind, act.fill_kind);
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // DUT hookup
   // ------------------------------------------------------------------------
   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;   // [2:0] op, [34:3] addr, [35] line_valid, [36] line_dirty
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;   // [0] hit, [3:1] way, [4] writeback,
                                  // [36:5] writeback_addr, [38:37] fill_kind

   tag_scoreboard sb = new();

   // idle rates in percent, changed by the stimulus between phases
   int send_idle_pct = 17;
   int rsp_idle_pct  = 58;

   logic [TAG_W-1:0] tag_pool [TAG_POOL];
   logic [IDX_W-1:0] set_pool [SET_POOL];

   set_assoc_lru_cache_tags uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 2 ns clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // hard stop well past the slowest legal run
   initial begin
      #400_000;
      $display("== FAIL ==");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Request side helpers
   // ------------------------------------------------------------------------
   function automatic request_type make_request(logic [OP_W-1:0] op,
                                                logic [ADDR_W-1:0] addr,
                                                logic lv, logic ld);
      request_type r;
      r.op         = op;
      r.addr       = addr;
      r.line_valid = lv;
      r.line_dirty = ld;
      return r;
   endfunction

   // mostly pooled tags/sets so lines hit, fill and get evicted;
   // one in ten is a fully random address, a few percent are illegal ops
   function automatic request_type random_request();
      request_type r;
      if ($urandom_range(99) < 6)
         r.op = OP_W'($urandom_range(OP_UNKNOWN_FIRST, OP_UNKNOWN_LAST));
      else
         r.op = OP_W'($urandom_range(OP_READ, OP_COPY));
      if ($urandom_range(9) == 0)
         r.addr = $urandom();
      else
         r.addr = {tag_pool[$urandom_range(TAG_POOL-1)],
                   set_pool[$urandom_range(SET_POOL-1)],
                   OFF_W'($urandom_range(2**OFF_W - 1))};
      r.line_valid = 1'($urandom_range(1));
      r.line_dirty = 1'($urandom_range(1));
      return r;
   endfunction

   // offer one request, hold it until accepted, then maybe idle a while;
   // valid stays up between back-to-back requests
   task automatic send_request(request_type r);
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_W - $bits(request_type)){1'b0}}, r};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(r);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   // stop offering and wait for every outstanding response
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Response side: random ready, one long hold to back the pipe up
   // ------------------------------------------------------------------------
   initial begin
      int unsigned rsp_count;
      int          hold_left;
      rsp_count = 0;
      hold_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            sb.check_response(rsp_tdata);
            rsp_count++;
            if (rsp_count == HOLD_AT) hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;

      tag_pool[0] = '0;
      tag_pool[1] = '1;
      for (int i = 2; i < TAG_POOL; i++) tag_pool[i] = TAG_W'($urandom());
      set_pool[0] = '0;
      set_pool[1] = '1;
      set_pool[2] = IDX_W'($urandom());
      set_pool[3] = IDX_W'($urandom());

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed: extremes, every op, illegal ops, dirty eviction ---
      send_request(make_request(OP_READ,  32'h0000_0000, 1'b0, 1'b0)); // cold miss
      send_request(make_request(OP_READ,  32'h0000_003F, 1'b0, 1'b0)); // same line hit
      send_request(make_request(OP_WRITE, 32'hFFFF_FFFF, 1'b1, 1'b1)); // top set/tag
      send_request(make_request(OP_TOUCH, 32'hFFFF_FFC0, 1'b0, 1'b0)); // touch hit
      send_request(make_request(OP_TOUCH, 32'h1234_5678, 1'b1, 1'b1)); // touch miss
      send_request(make_request(OP_ALLOC, 32'h0000_4000, 1'b0, 1'b0)); // zero fill
      send_request(make_request(OP_ALLOC, 32'h0000_4000, 1'b0, 1'b0)); // alloc hit
      send_request(make_request(OP_UNKNOWN_FIRST, 32'hFFFF_FFFF, 1'b1, 1'b1));
      send_request(make_request(OP_UNKNOWN_MID,   32'h0000_0000, 1'b1, 1'b0));
      send_request(make_request(OP_UNKNOWN_LAST,  32'hA5A5_5A5A, 1'b0, 1'b1));
      send_request(make_request(OP_COPY,  32'h0000_0000, 1'b1, 1'b1)); // copy on hit
      send_request(make_request(OP_COPY,  32'h0000_8000, 1'b0, 1'b0)); // copy invalid
      send_request(make_request(OP_COPY,  32'h0000_C000, 1'b1, 1'b0));
      // fill one set with dirty lines, then force dirty victims out
      for (int t = 1; t <= N_WAYS; t++)
         send_request(make_request(OP_WRITE,
            (ADDR_W'(t) << (OFF_W + IDX_W)) | (ADDR_W'(DIRECTED_SET) << OFF_W),
            1'b0, 1'b0));
      send_request(make_request(OP_READ,
         (ADDR_W'(N_WAYS + 1) << (OFF_W + IDX_W)) | (ADDR_W'(DIRECTED_SET) << OFF_W),
         1'b0, 1'b0));
      send_request(make_request(OP_COPY,
         (ADDR_W'(N_WAYS + 2) << (OFF_W + IDX_W)) | (ADDR_W'(DIRECTED_SET) << OFF_W),
         1'b1, 1'b1));

      // --- random, phase 1: light sender idling, heavy receiver idling ---
      for (int i = 0; i < PHASE_ITEMS; i++) send_request(random_request());

      // sender pauses until the block has answered everything
      wait_drained();

      // --- phase 2: roles swapped ---
      send_idle_pct = 58;
      rsp_idle_pct  = 17;
      for (int i = 0; i < PHASE_ITEMS; i++) send_request(random_request());

      // --- phase 3: full rate both sides; the receiver's long hold lands here ---
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      for (int i = 0; i < PHASE_ITEMS; i++) send_request(random_request());

      wait_drained();
      repeat (8) @(posedge clock);   // catch any stray late response
      if (sb.errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

FILE: sim.f
src/salc_pkg.sv
src/salc_ram.sv
src/salc_lookup.sv
src/set_assoc_lru_cache_tags.sv
dv/tb_set_assoc_lru_cache_tags.sv
